### sv/pps_pkg.sv
// pps_pkg: shared types and constants for the pick-and-place motion sequencer
// used by pick_place_motion_sequencer and its port checker; no dependencies
`default_nettype none

package pps_pkg;

	// input item fields
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned IN_DATA_W = 8;

	// result item fields
	localparam int unsigned STEP_W     = 11;
	localparam int unsigned ANGLE_W    = 8;
	localparam int unsigned OUT_DATA_W = 40;

	// field offsets inside m_tdata
	localparam int unsigned OFS_X    = 0;
	localparam int unsigned OFS_Y    = 11;
	localparam int unsigned OFS_SRV  = 22;
	localparam int unsigned OFS_NEG  = 30;
	localparam int unsigned OFS_POS  = 31;
	localparam int unsigned OFS_DONE = 32;

	// configuration register widths
	localparam int unsigned MAXS_W = 10;
	localparam int unsigned SPC_W  = 13;
	localparam int unsigned PROD_W = IDX_W + SPC_W;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_MAX_STEPS = 2'd0,
		REG_SPC_X     = 2'd1,
		REG_SPC_Y     = 2'd2,
		REG_SERVO_LOW = 2'd3
	} reg_idx_t;

	// register reset values
	localparam logic [MAXS_W-1:0]  MAXS_RST      = 10'd100;
	localparam logic [SPC_W-1:0]   SPC_RST       = 13'd200;
	localparam logic [ANGLE_W-1:0] SERVO_LOW_RST = 8'd90;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX     = 8'd180;

	// input item kinds carried on s_tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_MOVE = 1'b1;

	// plan phase, one-hot
	typedef enum logic [4:0] {
		PH_MOVE  = 5'b00001,
		PH_LOWER = 5'b00010,
		PH_DROP  = 5'b00100,
		PH_RAISE = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

endpackage

`default_nettype wire

### sv/pick_place_motion_sequencer.sv
// pick_place_motion_sequencer: gantry placement sequencer with stream channels
// and an apb-style register port; depends on pps_pkg
`default_nettype none

// How to use this block
// - slave channel s_*: one item per handshake; s_tuser = 1 starts a new
//   placement (row, column, player in s_tdata), s_tuser = 0 is a time tick
// - master channel m_*: exactly one result item for every accepted item,
//   in order; it carries the axis steps, servo angle, magnet pins, done flag
// - the result is registered: the result of an item accepted at edge n shows on
//   m_tvalid/m_tdata after edge n
// - throughput is one item per cycle while the receiver takes results; the state
//   update (clamped step, two 3x13 cell products, phase advance) fits between
//   the state registers and the single result register
// - when the receiver stalls, the result register holds and s_tready drops;
//   s_tready is high whenever the result register is empty or being taken
// - reset (arst_n low) empties the result register, puts the plan in the
//   done phase, clears positions and targets, raises the arm, switches the
//   magnet off and loads the register defaults (100, 200, 200, 90)
// - registers must be written only while the block is idle (the block itself does
//   not enforce it); reads return the stored value with pready always high
module pick_place_motion_sequencer #(
	parameter int unsigned BOARD_CELLS   = 8,
	parameter int unsigned POSITION_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [pps_pkg::IN_DATA_W-1:0]  s_tdata,  // row_index[2:0], col_index[5:3], player_white[6], zero[7]
	input  wire logic                           s_tuser,  // opcode
	// master stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [pps_pkg::OUT_DATA_W-1:0]      m_tdata,  // x_steps[10:0], y_steps[21:11], servo_angle[29:22], magnet_neg[30], magnet_pos[31], plan_done[32], zero[39:33]
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pps_pkg::ADDR_W-1:0]     paddr,
	input  wire logic [pps_pkg::DATA_W-1:0]     pwdata,
	output logic [pps_pkg::DATA_W-1:0]          prdata,
	output logic                                pready
);
	import pps_pkg::*;

	localparam int unsigned PW  = POSITION_BITS;
	localparam int unsigned DW  = POSITION_BITS + 1;     // signed distance width
	localparam logic [IDX_W-1:0] CELL_MAX = IDX_W'(BOARD_CELLS - 1);

	// configuration registers
	logic [MAXS_W-1:0]  max_steps_q;
	logic [SPC_W-1:0]   spc_x_q;
	logic [SPC_W-1:0]   spc_y_q;
	logic [ANGLE_W-1:0] servo_low_q;

	// sequencer state
	logic [PW-1:0]      pos_x_q, pos_y_q, tgt_x_q, tgt_y_q;
	phase_t             phase_q;
	logic [ANGLE_W-1:0] servo_q;
	logic               tgt_pos_q;
	logic               mag_neg_q, mag_pos_q;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// next-state values
	logic [PW-1:0]      pos_x_d, pos_y_d, tgt_x_d, tgt_y_d;
	phase_t             phase_d;
	logic [ANGLE_W-1:0] servo_d;
	logic               tgt_pos_d, mag_neg_d, mag_pos_d;
	logic [STEP_W-1:0]  xs, ys;

	logic               in_acc, cfg_wr;
	reg_idx_t           cfg_idx;
	logic [IDX_W-1:0]   row_c, col_c, row_in, col_in;
	logic [PROD_W-1:0]  prod_x, prod_y;
	logic [ANGLE_W-1:0] low_sat;

	assign pready   = 1'b1;
	assign cfg_idx  = reg_idx_t'(paddr[3:2]);
	assign cfg_wr   = psel && penable && pwrite && pready;

	// no buffering beyond the result register
	assign s_tready = !out_valid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		unique case (cfg_idx)
			REG_MAX_STEPS: prdata = DATA_W'(max_steps_q);
			REG_SPC_X:     prdata = DATA_W'(spc_x_q);
			REG_SPC_Y:     prdata = DATA_W'(spc_y_q);
			REG_SERVO_LOW: prdata = DATA_W'(servo_low_q);
			default:       prdata = '0;
		endcase
	end

	// clamped signed step toward the target, in -lim..+lim
	function automatic logic [STEP_W-1:0] step_toward(
		input logic [PW-1:0]     pos,
		input logic [PW-1:0]     tgt,
		input logic [MAXS_W-1:0] lim
	);
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] l;
		logic [STEP_W-1:0]    r;
		d = $signed({1'b0, tgt}) - $signed({1'b0, pos});
		l = $signed(DW'(lim));
		if (d > l) begin
			r = STEP_W'(lim);
		end else if (d < -l) begin
			r = -STEP_W'(lim);
		end else begin
			r = d[STEP_W-1:0];
		end
		return r;
	endfunction

	// target cell saturates at the board edge
	assign row_in  = s_tdata[IDX_W-1:0];
	assign col_in  = s_tdata[2*IDX_W-1:IDX_W];
	assign row_c   = (32'(row_in) >= BOARD_CELLS) ? CELL_MAX : row_in;
	assign col_c   = (32'(col_in) >= BOARD_CELLS) ? CELL_MAX : col_in;
	assign prod_x  = PROD_W'(row_c) * PROD_W'(spc_x_q);
	assign prod_y  = PROD_W'(col_c) * PROD_W'(spc_y_q);
	assign low_sat = (servo_low_q > ANGLE_MAX) ? ANGLE_MAX : servo_low_q;

	always_comb begin
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		tgt_x_d   = tgt_x_q;
		tgt_y_d   = tgt_y_q;
		phase_d   = phase_q;
		servo_d   = servo_q;
		tgt_pos_d = tgt_pos_q;
		mag_neg_d = mag_neg_q;
		mag_pos_d = mag_pos_q;
		xs        = '0;
		ys        = '0;
		if (s_tuser == OP_MOVE) begin
			// new placement: products wrap to the position width
			tgt_x_d   = PW'(prod_x);
			tgt_y_d   = PW'(prod_y);
			tgt_pos_d = s_tdata[2*IDX_W];
			phase_d   = PH_MOVE;
		end else begin
			unique case (phase_q)
				PH_MOVE: begin
					xs      = step_toward(pos_x_q, tgt_x_q, max_steps_q);
					ys      = step_toward(pos_y_q, tgt_y_q, max_steps_q);
					pos_x_d = pos_x_q + {{(PW-STEP_W){xs[STEP_W-1]}}, xs};
					pos_y_d = pos_y_q + {{(PW-STEP_W){ys[STEP_W-1]}}, ys};
					if (xs == '0 && ys == '0) begin
						phase_d = PH_LOWER;
					end
				end
				PH_LOWER: begin
					servo_d = low_sat;
					phase_d = PH_DROP;
				end
				PH_DROP: begin
					// drop with the polarity opposite the piece
					mag_neg_d = tgt_pos_q;
					mag_pos_d = !tgt_pos_q;
					phase_d   = PH_RAISE;
				end
				PH_RAISE: begin
					servo_d = '0;
					phase_d = PH_DONE;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q <= MAXS_RST;
			spc_x_q     <= SPC_RST;
			spc_y_q     <= SPC_RST;
			servo_low_q <= SERVO_LOW_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MAX_STEPS: max_steps_q <= pwdata[MAXS_W-1:0];
				REG_SPC_X:     spc_x_q     <= pwdata[SPC_W-1:0];
				REG_SPC_Y:     spc_y_q     <= pwdata[SPC_W-1:0];
				REG_SERVO_LOW: servo_low_q <= pwdata[ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			phase_q     <= PH_DONE;
			servo_q     <= '0;
			tgt_pos_q   <= 1'b0;
			mag_neg_q   <= 1'b0;
			mag_pos_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			pos_x_q     <= pos_x_d;
			pos_y_q     <= pos_y_d;
			tgt_x_q     <= tgt_x_d;
			tgt_y_q     <= tgt_y_d;
			phase_q     <= phase_d;
			servo_q     <= servo_d;
			tgt_pos_q   <= tgt_pos_d;
			mag_neg_q   <= mag_neg_d;
			mag_pos_q   <= mag_pos_d;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q <= {7'd0, (phase_d == PH_DONE), mag_pos_d, mag_neg_d, servo_d, ys, xs};
		end
	end

endmodule

`default_nettype wire

### sv/pps_checker.sv
// pps_checker: port-level checks for pick_place_motion_sequencer
// bound to the top level below; depends on pps_pkg
`default_nettype none

module pps_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          s_tuser,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [pps_pkg::OUT_DATA_W-1:0] m_tdata
);
	import pps_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// every accepted item yields a result in the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("result missing one cycle after accept");

	// an empty output side never blocks the input
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a move item issues no steps and reopens the plan
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_MOVE) |=>
		(m_tdata[OFS_Y-1:OFS_X] == '0) && (m_tdata[OFS_SRV-1:OFS_Y] == '0)
		&& !m_tdata[OFS_DONE])
		else $error("move item result not clean");

	// magnet pins never both driven
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[OFS_NEG] && m_tdata[OFS_POS]))
		else $error("both magnet pins high");

endmodule

bind pick_place_motion_sequencer pps_checker u_pps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

### tb/testbench.sv
// testbench for pick_place_motion_sequencer: self-checking stream and register test
// needs pps_pkg and the sequencer rtl; everything else is generated in this file
`timescale 1ns / 100ps

module testbench;
	import pps_pkg::*;

	localparam int CELLS        = 8;
	localparam int POS_W        = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_TAIL   = 60;    // last items of the random part run without idling
	localparam int REPORT_LIMIT = 50;    // mismatches beyond this are only counted

	// magnet drive as the sequencer keeps it
	typedef enum logic [1:0] {
		MAG_OFF,
		MAG_NEG,
		MAG_POS
	} magnet_t;

	// one result item, unpacked into its fields
	typedef struct {
		logic [STEP_W-1:0]  x_steps;
		logic [STEP_W-1:0]  y_steps;
		logic [ANGLE_W-1:0] servo_angle;
		logic               magnet_neg;
		logic               magnet_pos;
		logic               plan_done;
	} gantry_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // row_index[2:0], col_index[5:3], player_white[6], zero[7]
	logic                  s_tuser  = OP_TICK; // opcode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata; // x_steps[10:0], y_steps[21:11], servo_angle[29:22],
	                                // magnet_neg[30], magnet_pos[31], plan_done[32], zero[39:33]
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [ADDR_W-1:0]     paddr    = '0;
	logic [DATA_W-1:0]     pwdata   = '0;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;

	// shadow of the configuration registers, loaded with the reset defaults
	logic [MAXS_W-1:0]  max_steps_q = MAXS_RST;
	logic [SPC_W-1:0]   spc_x_q     = SPC_RST;
	logic [SPC_W-1:0]   spc_y_q     = SPC_RST;
	logic [ANGLE_W-1:0] lowered_q   = SERVO_LOW_RST;

	// gantry state as the predictor sees it after every accepted item
	logic [POS_W-1:0]   pos_x       = '0;
	logic [POS_W-1:0]   pos_y       = '0;
	logic [POS_W-1:0]   goal_x      = '0;
	logic [POS_W-1:0]   goal_y      = '0;
	phase_t             plan_phase  = PH_DONE;
	logic [ANGLE_W-1:0] servo_q     = '0;
	logic               piece_white = 1'b0;
	magnet_t            magnet_q    = MAG_OFF;

	gantry_result_t pending_results[$];

	int  items_sent    = 0;
	int  moves_sent    = 0;
	int  results_seen  = 0;
	int  errors        = 0;
	int  settings_done = 0;
	int  stall_left    = 0;
	bit  idle_on       = 1'b1;

	pick_place_motion_sequencer #(
		.BOARD_CELLS  (CELLS),
		.POSITION_BITS(POS_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// signed distance to the goal, limited to +/- lim
	function automatic int clamp_step(int delta, int lim);
		if (delta > lim)
			return lim;
		if (delta < -lim)
			return -lim;
		return delta;
	endfunction

	// applies one item to the shadow state and returns the result it causes
	function automatic gantry_result_t advance_gantry(logic op, logic [IDX_W-1:0] row,
			logic [IDX_W-1:0] col, logic white);
		int             dx;
		int             dy;
		int             row_cell;
		int             col_cell;
		gantry_result_t r;
		dx = 0;
		dy = 0;
		if (op == OP_MOVE) begin
			// indexes past the board edge stick to the last cell
			row_cell    = (int'(row) >= CELLS) ? CELLS - 1 : int'(row);
			col_cell    = (int'(col) >= CELLS) ? CELLS - 1 : int'(col);
			// goal wraps at the position width
			goal_x      = POS_W'(row_cell * int'(spc_x_q));
			goal_y      = POS_W'(col_cell * int'(spc_y_q));
			piece_white = white;
			plan_phase  = PH_MOVE;
		end else begin
			case (plan_phase)
				PH_MOVE: begin
					dx    = clamp_step(int'(goal_x) - int'(pos_x), int'(max_steps_q));
					dy    = clamp_step(int'(goal_y) - int'(pos_y), int'(max_steps_q));
					pos_x = pos_x + POS_W'(dx);
					pos_y = pos_y + POS_W'(dy);
					// a tick with no motion on either axis closes the move phase
					if (dx == 0 && dy == 0)
						plan_phase = PH_LOWER;
				end
				PH_LOWER: begin
					servo_q    = (lowered_q > ANGLE_MAX) ? ANGLE_MAX : lowered_q;
					plan_phase = PH_DROP;
				end
				PH_DROP: begin
					// release by flipping to the polarity opposite the piece
					magnet_q   = piece_white ? MAG_NEG : MAG_POS;
					plan_phase = PH_RAISE;
				end
				PH_RAISE: begin
					servo_q    = '0;
					plan_phase = PH_DONE;
				end
				default: ;
			endcase
		end
		r.x_steps     = STEP_W'(dx);
		r.y_steps     = STEP_W'(dy);
		r.servo_angle = servo_q;
		r.magnet_neg  = (magnet_q == MAG_NEG);
		r.magnet_pos  = (magnet_q == MAG_POS);
		r.plan_done   = (plan_phase == PH_DONE);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (got !== want) begin
			errors++;
			if (errors <= REPORT_LIMIT)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	// result side: every accepted result is matched against the oldest prediction
	always @(posedge clk) begin : check_result
		gantry_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$error("result item with no item waiting for it");
			end else begin
				want = pending_results.pop_front();
				check_field("x_steps", 32'($signed(want.x_steps)),
					32'($signed(m_tdata[OFS_X +: STEP_W])));
				check_field("y_steps", 32'($signed(want.y_steps)),
					32'($signed(m_tdata[OFS_Y +: STEP_W])));
				check_field("servo_angle", 32'(want.servo_angle),
					32'(m_tdata[OFS_SRV +: ANGLE_W]));
				check_field("magnet_neg", 32'(want.magnet_neg), 32'(m_tdata[OFS_NEG]));
				check_field("magnet_pos", 32'(want.magnet_pos), 32'(m_tdata[OFS_POS]));
				check_field("plan_done", 32'(want.plan_done), 32'(m_tdata[OFS_DONE]));
			end
		end
	end

	// receiver: ready, with random stall bursts of random length
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_tready   <= 1'b0;
			stall_left = $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// offers one item, waits for the handshake, predicts, then maybe idles a while;
	// tvalid is left high when the next item follows straight away
	task automatic send_item(logic op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
			logic white);
		s_tuser  <= op;
		s_tdata  <= {1'b0, white, col, row};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(advance_gantry(op, row, col, white));
		items_sent++;
		if (op == OP_MOVE)
			moves_sent++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// ticks carry random payload bits, which the block must ignore
	task automatic tick();
		send_item(OP_TICK, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
	endtask

	// starts a placement and ticks it through its phases, with a safety cap
	task automatic run_placement(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
			logic white, int cap);
		int n;
		n = 0;
		send_item(OP_MOVE, row, col, white);
		while (plan_phase != PH_DONE && n < cap) begin
			tick();
			n++;
		end
	endtask

	// holds the sender until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// writes one register and reads it back; psel stays up between the two transfers
	task automatic program_register(reg_idx_t idx, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_MAX_STEPS: begin
				max_steps_q = value[MAXS_W-1:0];
				want        = DATA_W'(max_steps_q);
			end
			REG_SPC_X: begin
				spc_x_q = value[SPC_W-1:0];
				want    = DATA_W'(spc_x_q);
			end
			REG_SPC_Y: begin
				spc_y_q = value[SPC_W-1:0];
				want    = DATA_W'(spc_y_q);
			end
			default: begin
				lowered_q = value[ANGLE_W-1:0];
				want      = DATA_W'(lowered_q);
			end
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		check_field("prdata", want, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// parks the gantry at the origin, so that the next setting starts from a known
	// position, then loads all four registers while the block is idle
	task automatic apply_setting(int ms, int sx, int sy, int ang);
		run_placement(3'd0, 3'd0, 1'($urandom), 100_000);
		drain_results();
		program_register(REG_MAX_STEPS, DATA_W'(ms));
		program_register(REG_SPC_X, DATA_W'(sx));
		program_register(REG_SPC_Y, DATA_W'(sy));
		program_register(REG_SERVO_LOW, DATA_W'(ang));
		settings_done++;
	endtask

	// one placement with random content; now and then the plan is cut short by a
	// second move item, and a few ticks trail behind the finished plan
	task automatic random_sequence();
		int n;
		n = 0;
		send_item(OP_MOVE, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(0, 4)) tick();
			send_item(OP_MOVE, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
		end
		while (plan_phase != PH_DONE && n < 200) begin
			tick();
			n++;
		end
		repeat ($urandom_range(0, 2)) tick();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// defaults after reset: idle tick, one placement one cell in, tick while done
	task automatic test_reset_state();
		tick();
		run_placement(3'd1, 3'd1, 1'b1, 50);
		tick();
	endtask

	// far corner with tiny cells, so the clamp and the last partial step both show
	task automatic test_corner_placement();
		apply_setting(5, 3, 2, int'(ANGLE_MAX));
		run_placement(3'd7, 3'd7, 1'b1, 50);
	endtask

	// register extremes: zero step limit, zero and full cell sizes, angles 0, 180, 181 and 255
	task automatic test_register_extremes();
		apply_setting(1, 1, 3, int'(ANGLE_MAX));
		repeat (2) random_sequence();
		apply_setting(1023, 8191, 8191, 0);
		repeat (2) random_sequence();
		apply_setting(0, 8191, 1, 255);
		repeat (2) random_sequence();
		apply_setting(1023, 0, 8191, 181);
		repeat (2) random_sequence();
		apply_setting(int'(MAXS_RST), int'(SPC_RST), int'(SPC_RST), int'(SERVO_LOW_RST));
		repeat (2) random_sequence();
	endtask

	// random settings, each followed by a handful of placements; cell sizes stay
	// within a few dozen ticks of travel for the chosen step limit
	task automatic test_random_plans();
		int first;
		int setting_no;
		int ms;
		int spc_cap;
		first      = items_sent;
		setting_no = 0;
		while (items_sent - first < RANDOM_ITEMS) begin
			ms      = $urandom_range(1, 1023);
			spc_cap = (ms * 4 > 8191) ? 8191 : ms * 4;
			apply_setting(ms, $urandom_range(0, spc_cap), $urandom_range(0, spc_cap),
				$urandom_range(0, 255));
			// stretches without idling, and none at all near the end
			idle_on = (setting_no % 4 != 3) && (items_sent - first < RANDOM_ITEMS - QUIET_TAIL);
			send_item(OP_MOVE, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
			// once, hold the sender in the middle of a plan until the block is empty
			if (setting_no == 1)
				drain_results();
			repeat ($urandom_range(3, 8)) random_sequence();
			setting_no++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_corner_placement();
		test_register_extremes();
		test_random_plans();

		drain_results();
		repeat (5) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$error("%0d predicted results never arrived", pending_results.size());
		end

		$display("run covered %0d items, %0d of them placements, over %0d register settings",
			items_sent, moves_sent, settings_done);
		$display("%0d result items compared, %0d mismatches", results_seen, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### files.f
sv/pps_pkg.sv
sv/pick_place_motion_sequencer.sv
sv/pps_checker.sv
tb/testbench.sv
